### rtl/rv32iex_pkg.sv
package rv32iex_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = 5;

  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;

  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_JALR = 3'b000;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [XLEN-1:0] PC_STEP    = 32'd4;
  localparam logic [XLEN-1:0] CLEAR_BIT0 = ~32'd1;

endpackage

### rtl/rv32iex_ram.sv
module rv32iex_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rv32i_integer_execute_unit_top.sv
// path: an accepted word is held in the execute stage with its registered operand reads,
// and its result is registered in the output stage, which drives out_valid_o
// throughput: one word per cycle while the output is not stalled, with the register
// file memory read registered and writeback forwarded to a read in the same cycle
// reset: pc cleared, per-register valid bits cleared so every register reads
// as zero; no clearing pass, words accepted straight after reset
module rv32i_integer_execute_unit_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [31:0]                          instruction_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rv32iex_pkg::XLEN-1:0]         next_pc_o,
  output logic                                 write_enable_o,
  output logic [rv32iex_pkg::REG_AW-1:0]       write_index_o,
  output logic [rv32iex_pkg::XLEN-1:0]         write_value_o,
  output logic                                 branch_taken_o,
  output logic                                 illegal_o
);
  import rv32iex_pkg::*;

  logic                 in_accept;
  logic                 out_free;
  logic                 ex_fire;
  logic                 ex_valid_q, ex_valid_d;
  logic [31:0]          ins_q;
  logic                 out_valid_q, out_valid_d;
  logic [REG_COUNT-1:0] rf_valid_q, rf_valid_d;
  logic [XLEN-1:0]      pc_q, pc_d;

  logic [REG_AW-1:0]    rs1_in, rs2_in;
  logic                 fwd_a_q, fwd_b_q;
  logic                 ok_a_q, ok_b_q;
  logic [XLEN-1:0]      fwd_val_q;
  logic [XLEN-1:0]      ram_a, ram_b;

  logic [6:0]           opc, f7;
  logic [2:0]           f3;
  logic [REG_AW-1:0]    rd, shamt;
  logic [XLEN-1:0]      a, b, imm_i, imm_b, imm_j, pc_plus4;
  logic [XLEN-1:0]      val, npc, wb_val;
  logic                 wr, taken, bad, wb_en;
  logic [REG_AW-1:0]    wb_idx;
  logic                 rf_we;

  logic [XLEN-1:0]      next_pc_q;
  logic                 write_enable_q;
  logic [REG_AW-1:0]    write_index_q;
  logic [XLEN-1:0]      write_value_q;
  logic                 branch_taken_q;
  logic                 illegal_q;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ex_fire    = ex_valid_q && out_free;
  assign in_stall_o = ex_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign rs1_in = instruction_word_i[19:15];
  assign rs2_in = instruction_word_i[24:20];
  assign rf_we  = ex_fire && wb_en;

  // register file, one copy per read port
  rv32iex_ram #(
    .WIDTH (XLEN),
    .DEPTH (REG_COUNT)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (wb_idx),
    .wdata_i (wb_val),
    .re_i    (in_accept),
    .raddr_i (rs1_in),
    .rdata_o (ram_a)
  );

  rv32iex_ram #(
    .WIDTH (XLEN),
    .DEPTH (REG_COUNT)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (wb_idx),
    .wdata_i (wb_val),
    .re_i    (in_accept),
    .raddr_i (rs2_in),
    .rdata_o (ram_b)
  );

  // operands with writeback forwarding
  assign a = fwd_a_q ? fwd_val_q : (ok_a_q ? ram_a : '0);
  assign b = fwd_b_q ? fwd_val_q : (ok_b_q ? ram_b : '0);

  // decode
  assign opc      = ins_q[6:0];
  assign rd       = ins_q[11:7];
  assign f3       = ins_q[14:12];
  assign shamt    = ins_q[24:20];
  assign f7       = ins_q[31:25];
  assign imm_i    = {{20{ins_q[31]}}, ins_q[31:20]};
  assign imm_b    = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
  assign imm_j    = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21],
                     1'b0};
  assign pc_plus4 = pc_q + PC_STEP;

  always_comb begin
    val   = '0;
    npc   = pc_plus4;
    wr    = 1'b0;
    taken = 1'b0;
    bad   = 1'b0;
    case (opc)
      OPC_REG: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[REG_AW-1:0];
            F3_SLT:  val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[REG_AW-1:0];
            F3_OR:   val = a | b;
            F3_AND:  val = a & b;
            default: bad = 1'b1;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = a - b;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm_i;
          F3_SLT:  val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm_i)};
          F3_SLTU: val = {{(XLEN-1){1'b0}}, a < imm_i};
          F3_XOR:  val = a ^ imm_i;
          F3_OR:   val = a | imm_i;
          F3_AND:  val = a & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << shamt;
            else bad = 1'b1;
          end
          F3_SR: begin
            if (f7 == F7_BASE) val = a >> shamt;
            else if (f7 == F7_ALT) val = XLEN'($signed(a) >>> shamt);
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          default: bad = 1'b1;
        endcase
        if (taken) npc = pc_q + imm_b;
      end
      OPC_JAL: begin
        wr    = 1'b1;
        taken = 1'b1;
        val   = pc_plus4;
        npc   = pc_q + imm_j;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          wr    = 1'b1;
          taken = 1'b1;
          val   = pc_plus4;
          npc   = (a + imm_i) & CLEAR_BIT0;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      wr    = 1'b0;
      taken = 1'b0;
      npc   = pc_q;
    end
  end

  assign wb_en  = wr && (rd != '0);
  assign wb_idx = wb_en ? rd : '0;
  assign wb_val = wb_en ? val : '0;

  // control next state
  always_comb begin
    ex_valid_d = ex_valid_q;
    if (in_accept) ex_valid_d = 1'b1;
    else if (ex_fire) ex_valid_d = 1'b0;
    out_valid_d = ex_fire || (out_valid_q && out_stall_i);
    pc_d        = ex_fire ? npc : pc_q;
    rf_valid_d  = rf_valid_q;
    if (rf_we) rf_valid_d[wb_idx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      rf_valid_q  <= '0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      pc_q        <= pc_d;
      rf_valid_q  <= rf_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ins_q     <= instruction_word_i;
      fwd_a_q   <= rf_we && (wb_idx == rs1_in);
      fwd_b_q   <= rf_we && (wb_idx == rs2_in);
      ok_a_q    <= rf_valid_q[rs1_in];
      ok_b_q    <= rf_valid_q[rs2_in];
      fwd_val_q <= wb_val;
    end
    if (ex_fire) begin
      next_pc_q      <= npc;
      write_enable_q <= wb_en;
      write_index_q  <= wb_idx;
      write_value_q  <= wb_val;
      branch_taken_q <= taken;
      illegal_q      <= bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = next_pc_q;
  assign write_enable_o = write_enable_q;
  assign write_index_o  = write_index_q;
  assign write_value_o  = write_value_q;
  assign branch_taken_o = branch_taken_q;
  assign illegal_o      = illegal_q;

`ifndef SYNTH
  a_x0_never_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_valid_q[0])
    else $error("x0 marked as written");

  a_illegal_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_o |-> !write_enable_o && !branch_taken_o)
    else $error("illegal word changed state");

  a_illegal_pc_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && bad |=> pc_q == $past(pc_q))
    else $error("pc moved on illegal word");

  a_full_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_valid_q && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("word accepted with pipeline full");
`endif

endmodule

### tb/rv32i_integer_execute_unit_top_tb.sv
`timescale 1ns / 100ps

module rv32i_integer_execute_unit_top_tb;
  import rv32iex_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 650;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              write_enable;
    logic [REG_AW-1:0] write_index;
    logic [XLEN-1:0]   write_value;
    logic              branch_taken;
    logic              illegal;
  } exec_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [31:0]         instruction_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [XLEN-1:0]     next_pc_o;
  logic                write_enable_o;
  logic [REG_AW-1:0]   write_index_o;
  logic [XLEN-1:0]     write_value_o;
  logic                branch_taken_o;
  logic                illegal_o;

  logic [31:0]   word_queue[$];
  exec_result_t  pending_results[$];
  logic [XLEN-1:0] gpr_model [REG_COUNT] = '{default: '0};
  logic [XLEN-1:0] pc_model = '0;

  logic word_taken;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatch_count = 0;
  int   words_accepted = 0;
  int   results_checked = 0;
  int   illegal_seen = 0;
  int   redirects_seen = 0;
  int   cycle_count = 0;

  rv32i_integer_execute_unit_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instruction_word_i (instruction_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .next_pc_o          (next_pc_o),
    .write_enable_o     (write_enable_o),
    .write_index_o      (write_index_o),
    .write_value_o      (write_value_o),
    .branch_taken_o     (branch_taken_o),
    .illegal_o          (illegal_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // executes one word against the model registers and pc
  function automatic exec_result_t execute_word(logic [31:0] w);
    logic [6:0]      opc, f7;
    logic [4:0]      rd, rs1, rs2;
    logic [2:0]      f3;
    logic [XLEN-1:0] a, b, imm_i, imm_b, imm_j, npc, val;
    logic            wr, taken, bad;
    opc = w[6:0];
    rd  = w[11:7];
    f3  = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    f7  = w[31:25];
    a = gpr_model[rs1];
    b = gpr_model[rs2];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    npc = pc_model + PC_STEP;
    val = '0;
    wr = 1'b0;
    taken = 1'b0;
    bad = 1'b0;
    case (opc)
      OPC_REG: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[4:0];
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[4:0];
            F3_OR:   val = a | b;
            F3_AND:  val = a & b;
            default: bad = 1'b1;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = a - b;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm_i;
          F3_SLT:  val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
          F3_SLTU: val = (a < imm_i) ? 32'd1 : 32'd0;
          F3_XOR:  val = a ^ imm_i;
          F3_OR:   val = a | imm_i;
          F3_AND:  val = a & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << rs2;
            else bad = 1'b1;
          end
          default: begin
            if (f7 == F7_BASE) val = a >> rs2;
            else if (f7 == F7_ALT) val = $signed(a) >>> rs2;
            else bad = 1'b1;
          end
        endcase
      end
      OPC_BRANCH: begin
        if (f3 == F3_BEQ) taken = (a == b);
        else if (f3 == F3_BNE) taken = (a != b);
        else bad = 1'b1;
        if (taken) npc = pc_model + imm_b;
      end
      OPC_JAL: begin
        wr = 1'b1;
        taken = 1'b1;
        val = pc_model + PC_STEP;
        npc = pc_model + imm_j;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          wr = 1'b1;
          taken = 1'b1;
          val = pc_model + PC_STEP;
          npc = (a + imm_i) & CLEAR_BIT0;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      wr = 1'b0;
      taken = 1'b0;
      npc = pc_model;
    end
    if (!wr || rd == '0) begin
      wr = 1'b0;
      rd = '0;
      val = '0;
    end else begin
      gpr_model[rd] = val;
    end
    pc_model = npc;
    return '{npc, wr, rd, val, taken, bad};
  endfunction

  // mostly legal words with random operands, some near misses and raw noise
  function automatic logic [31:0] random_word();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    int         pick;
    rd   = 5'($urandom_range(31));
    rs1  = 5'($urandom_range(31));
    rs2  = 5'($urandom_range(31));
    f3   = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 30) begin
      if (f3 == F3_SLL) return enc_r(F7_BASE, rs2, rs1, f3, rd, OPC_IMM);
      if (f3 == F3_SR) return enc_r($urandom_range(1) ? F7_ALT : F7_BASE, rs2, rs1, f3, rd,
                                    OPC_IMM);
      return enc_i(12'($urandom), rs1, f3, rd, OPC_IMM);
    end else if (pick < 40) begin
      if ($urandom_range(2) == 0) return enc_r(F7_BASE, rs2, rs1, F3_SLL, rd, OPC_IMM);
      return enc_r($urandom_range(1) ? F7_ALT : F7_BASE, rs2, rs1, F3_SR, rd, OPC_IMM);
    end else if (pick < 60) begin
      // the sltu slot stands in for sub
      if (f3 == F3_SLTU) return enc_r(F7_ALT, rs2, rs1, F3_ADD, rd, OPC_REG);
      return enc_r(F7_BASE, rs2, rs1, f3, rd, OPC_REG);
    end else if (pick < 72) begin
      if ($urandom_range(1)) rs2 = rs1;
      return enc_b({12'($urandom_range(4095)), 1'b0}, rs2, rs1,
                   $urandom_range(1) ? F3_BNE : F3_BEQ);
    end else if (pick < 78) begin
      return enc_j({20'($urandom_range(20'hFFFFF)), 1'b0}, rd);
    end else if (pick < 84) begin
      return enc_i(12'($urandom), rs1, F3_JALR, rd, OPC_JALR);
    end else if (pick < 92) begin
      case ($urandom_range(3))
        0:       return enc_r(7'($urandom_range(127)), rs2, rs1, f3, rd, OPC_REG);
        1:       return enc_r(7'($urandom_range(127)), rs2, rs1,
                              $urandom_range(1) ? F3_SLL : F3_SR, rd, OPC_IMM);
        2:       return enc_b(13'($urandom), rs2, rs1, 3'($urandom_range(7, 2)));
        default: return enc_i(12'($urandom), rs1, 3'($urandom_range(7, 1)), rd, OPC_JALR);
      endcase
    end
    return $urandom;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic wait_drained();
    while (word_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid_i && !in_stall_o;
    end
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      instruction_word_i <= '0;
      out_stall_i <= 1'b0;
    end else begin
      if (!in_valid_i || word_taken) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          instruction_word_i <= word_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin : result_monitor
    exec_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(execute_word(instruction_word_i));
        words_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("next_pc", next_pc_o, want.next_pc);
          check_field("write_enable", 32'(write_enable_o), 32'(want.write_enable));
          check_field("write_index", 32'(write_index_o), 32'(want.write_index));
          check_field("write_value", write_value_o, want.write_value);
          check_field("branch_taken", 32'(branch_taken_o), 32'(want.branch_taken));
          check_field("illegal", 32'(illegal_o), 32'(want.illegal));
          results_checked++;
          if (want.illegal) illegal_seen++;
          if (want.branch_taken) redirects_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rv32i_integer_execute_unit_top");
      $finish;
    end
  end

  initial begin : stimulus
    int send_pct [3] = '{29, 63, 0};
    int recv_pct [3] = '{63, 29, 0};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    word_queue.push_back(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OPC_IMM));
    word_queue.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_IMM));
    word_queue.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_REG));
    word_queue.push_back(enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd4, OPC_REG));
    word_queue.push_back(enc_r(F7_BASE, 5'd2, 5'd3, F3_SLL, 5'd5, OPC_REG));
    word_queue.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd6, OPC_REG));
    word_queue.push_back(enc_r(F7_BASE, 5'd2, 5'd3, F3_XOR, 5'd7, OPC_REG));
    word_queue.push_back(enc_r(F7_BASE, 5'd2, 5'd3, F3_SR, 5'd8, OPC_REG));
    word_queue.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_OR, 5'd9, OPC_REG));
    word_queue.push_back(enc_r(F7_BASE, 5'd1, 5'd3, F3_AND, 5'd10, OPC_REG));
    word_queue.push_back(enc_i(12'hFFF, 5'd1, F3_SLT, 5'd11, OPC_IMM));
    word_queue.push_back(enc_i(12'hFFF, 5'd2, F3_SLTU, 5'd12, OPC_IMM));
    word_queue.push_back(enc_i(12'h800, 5'd3, F3_XOR, 5'd13, OPC_IMM));
    word_queue.push_back(enc_i(12'h555, 5'd0, F3_OR, 5'd14, OPC_IMM));
    word_queue.push_back(enc_i(12'h7FF, 5'd3, F3_AND, 5'd15, OPC_IMM));
    word_queue.push_back(enc_r(F7_BASE, 5'd31, 5'd3, F3_SLL, 5'd16, OPC_IMM));
    word_queue.push_back(enc_r(F7_ALT, 5'd31, 5'd16, F3_SR, 5'd17, OPC_IMM));
    word_queue.push_back(enc_r(F7_BASE, 5'd0, 5'd16, F3_SR, 5'd18, OPC_IMM));
    // write to x0 is dropped
    word_queue.push_back(enc_i(12'h005, 5'd3, F3_ADD, 5'd0, OPC_IMM));
    word_queue.push_back(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
    word_queue.push_back(enc_b(13'h0FFE, 5'd1, 5'd1, F3_BNE));
    word_queue.push_back(enc_j(21'h100000, 5'd1));
    // jalr with rd equal to rs1 and an odd target
    word_queue.push_back(enc_i(12'hFFF, 5'd16, F3_JALR, 5'd16, OPC_JALR));
    word_queue.push_back(32'hFFFF_FFFF);
    word_queue.push_back(enc_r(F7_ALT, 5'd2, 5'd1, F3_SLL, 5'd20, OPC_REG));
    word_queue.push_back(enc_r(F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd21, OPC_IMM));
    word_queue.push_back(enc_b(13'h0010, 5'd2, 5'd1, F3_SLT));
    word_queue.push_back(enc_i(12'h010, 5'd1, F3_SLL, 5'd22, OPC_JALR));
    // sender holds off until every result is back
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_idle_pct = recv_pct[phase];
      repeat (RANDOM_PER_PHASE) word_queue.push_back(random_word());
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("run covered %0d words, %0d results checked, %0d illegal, %0d redirects",
             words_accepted, results_checked, illegal_seen, redirects_seen);
    $display("stall mixes 29/63, 63/29 and none; %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS rv32i_integer_execute_unit_top");
    end else begin
      $display("FAIL rv32i_integer_execute_unit_top");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rv32iex_pkg.sv
rtl/rv32iex_ram.sv
rtl/rv32i_integer_execute_unit_top.sv
tb/rv32i_integer_execute_unit_top_tb.sv
